@@ hw/rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the command frame receiver modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SET_TIME,
        KIND_SET_TEMP,
        KIND_REQ_MEAS,
        KIND_CLR_MEAS
    } kind_t;

    localparam int unsigned NUM_CODES = 4;

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] END_BYTE   = 8'hFE;
    localparam logic [7:0] LEN_TIME   = 8'h0C;
    localparam logic [7:0] LEN_TEMP   = 8'h08;
    localparam logic [7:0] LEN_SHORT  = 8'h04;

    localparam logic [3:0] TEMP_BYTES = 4'd4;
    localparam logic [3:0] NO_BYTES   = 4'd0;

    localparam logic [7:0] RST_CODE_SET_TIME  = 8'h10;
    localparam logic [7:0] RST_CODE_SET_TEMP  = 8'h20;
    localparam logic [7:0] RST_CODE_REQ_MEAS  = 8'h30;
    localparam logic [7:0] RST_CODE_CLR_MEAS  = 8'h40;

    typedef logic [NUM_CODES-1:0][7:0] code_set_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [63:0] payload;
        logic [3:0]  count;
    } frame_t;

    function automatic logic [7:0] expected_len(kind_t kind);
        logic [7:0] len;
        case (kind)
            KIND_SET_TIME: len = LEN_TIME;
            KIND_SET_TEMP: len = LEN_TEMP;
            default:       len = LEN_SHORT;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/cfr_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser: walks start, command, length, payload and end bytes one
// request at a time and flags a completed frame combinationally.
// ----------------------------------------------------------------------------
module cfr_parser #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  cfr_pkg::code_set_t  codes,
    output cfr_pkg::frame_t     frame
);

    localparam int unsigned STORE_W = MAX_PAYLOAD_BYTES * 8;

    cfr_pkg::phase_t      phase_reg, phase_next;
    cfr_pkg::kind_t       kind_reg, kind_next;
    logic [3:0]           bytes_left_reg, bytes_left_next;
    logic [STORE_W-1:0]   store_reg, store_next;

    logic                 hit;
    cfr_pkg::kind_t       hit_kind;
    logic [3:0]           cur_count;
    logic [3:0]           left_dec;
    logic [2:0]           pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= cfr_pkg::PH_IDLE;
            kind_reg       <= cfr_pkg::KIND_SET_TIME;
            bytes_left_reg <= '0;
            store_reg      <= '0;
        end else begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            bytes_left_reg <= bytes_left_next;
            store_reg      <= store_next;
        end
    end

    always_comb begin
        case (kind_reg)
            cfr_pkg::KIND_SET_TIME: cur_count = 4'(MAX_PAYLOAD_BYTES);
            cfr_pkg::KIND_SET_TEMP: cur_count = cfr_pkg::TEMP_BYTES;
            default:                cur_count = cfr_pkg::NO_BYTES;
        endcase
    end

    assign left_dec = bytes_left_reg - 4'd1;
    assign pos      = 3'(cur_count - bytes_left_reg);

    // lowest kind wins on equal codes
    always_comb begin
        hit      = 1'b0;
        hit_kind = cfr_pkg::KIND_SET_TIME;
        for (int k = cfr_pkg::NUM_CODES - 1; k >= 0; k--) begin
            if (in_byte == codes[k]) begin
                hit      = 1'b1;
                hit_kind = cfr_pkg::kind_t'(k);
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        bytes_left_next = bytes_left_reg;
        store_next      = store_reg;
        frame.valid     = 1'b0;
        frame.kind      = kind_reg;
        frame.count     = cur_count;
        frame.payload   = (kind_reg == cfr_pkg::KIND_SET_TIME ||
                           kind_reg == cfr_pkg::KIND_SET_TEMP) ? 64'(store_reg) : 64'd0;
        if (in_valid) begin
            case (phase_reg)
                cfr_pkg::PH_CMD: begin
                    if (hit) begin
                        kind_next  = hit_kind;
                        phase_next = cfr_pkg::PH_LEN;
                    end else if (in_byte != cfr_pkg::START_BYTE) begin
                        phase_next = cfr_pkg::PH_IDLE;
                    end
                end
                cfr_pkg::PH_LEN: begin
                    if (in_byte == cfr_pkg::expected_len(kind_reg)) begin
                        store_next      = '0;
                        bytes_left_next = cur_count;
                        phase_next      = (cur_count != 4'd0) ? cfr_pkg::PH_DATA
                                                              : cfr_pkg::PH_END;
                    end else if (in_byte == cfr_pkg::START_BYTE) begin
                        phase_next = cfr_pkg::PH_CMD;
                    end else begin
                        phase_next = cfr_pkg::PH_IDLE;
                    end
                end
                cfr_pkg::PH_DATA: begin
                    for (int i = 0; i < int'(MAX_PAYLOAD_BYTES); i++) begin
                        if (pos == 3'(i)) begin
                            store_next[i*8 +: 8] = store_reg[i*8 +: 8] | in_byte;
                        end
                    end
                    bytes_left_next = left_dec;
                    if (left_dec == 4'd0) begin
                        phase_next = cfr_pkg::PH_END;
                    end
                end
                cfr_pkg::PH_END: begin
                    phase_next  = cfr_pkg::PH_IDLE;
                    frame.valid = (in_byte == cfr_pkg::END_BYTE);
                end
                default: begin
                    phase_next = (in_byte == cfr_pkg::START_BYTE) ? cfr_pkg::PH_CMD
                                                                 : cfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/command_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Finds command frames in a received serial byte stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one received byte per request, in arrival order.
// Output channel m_*: one request per correctly ended frame; m_tuser carries
// the command kind, m_tdata the payload (first byte lowest) and byte count.
// Frames: 0x01, command code, length byte, 0/4/MAX_PAYLOAD_BYTES payload
// bytes, 0xFE. Malformed frames are dropped without output.
// The result shows on m_* in the cycle after the end byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the parser state is registered
// and the output register lets a byte enter while a waiting result is taken.
// When the receiver stalls with a result pending, s_tready drops only once
// the output register is full and not being taken.
// Reset (aresetn low, synchronous): parser idle, output empty, command codes back to
// 0x10, 0x20, 0x30, 0x40. The user must write codes via cfg_* only when idle; unenforced.
// ----------------------------------------------------------------------------
module command_frame_receiver_core #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] frame_payload, [67:64] payload_count, zero pad
    output logic [1:0]  m_tuser    // [1:0] frame_kind
);

    cfr_pkg::code_set_t codes_reg;
    cfr_pkg::frame_t    frame;
    logic               s_accept;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg;
    logic [63:0]        payload_reg;
    logic [3:0]         count_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg[0] <= cfr_pkg::RST_CODE_SET_TIME;
            codes_reg[1] <= cfr_pkg::RST_CODE_SET_TEMP;
            codes_reg[2] <= cfr_pkg::RST_CODE_REQ_MEAS;
            codes_reg[3] <= cfr_pkg::RST_CODE_CLR_MEAS;
        end else if (cfg_wr_en) begin
            codes_reg[cfg_addr] <= cfg_wdata;
        end
    end

    cfr_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_accept),
        .in_byte  (s_tdata),
        .codes    (codes_reg),
        .frame    (frame)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (frame.valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame.valid) begin
            kind_reg    <= frame.kind;
            payload_reg <= frame.payload;
            count_reg   <= frame.count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'd0, count_reg, payload_reg};

    // frame only completes on an accepted request
    a_frame_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        frame.valid |-> s_accept)
        else $error("frame completed without an accepted request");

    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_accept))
        else $error("result appeared without an input request");

    a_count_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == 2'(cfr_pkg::KIND_SET_TIME) &&
                      m_tdata[67:64] == 4'(MAX_PAYLOAD_BYTES)) ||
                     (m_tuser == 2'(cfr_pkg::KIND_SET_TEMP) &&
                      m_tdata[67:64] == cfr_pkg::TEMP_BYTES) ||
                     (m_tuser[1] && m_tdata[67:64] == cfr_pkg::NO_BYTES))
        else $error("payload count does not match frame kind");

    a_no_payload_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[63:0] == 64'd0))
        else $error("payload-free frame carries payload");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output can drain");

endmodule
